/* rtl/cau_pkg.sv */
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Shared widths, operation and status codes, and beat/pipeline types.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int DataWidth = 16;
  localparam int FracBits  = 8;
  localparam int MagWidth  = 2 * DataWidth;
  localparam int NumWidth  = MagWidth + FracBits;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_DIV_ZERO = 2'd2
  } status_e;

  typedef struct packed {
    op_e                         operation;
    logic signed [DataWidth-1:0] a_real;
    logic signed [DataWidth-1:0] a_imag;
    logic signed [DataWidth-1:0] b_real;
    logic signed [DataWidth-1:0] b_imag;
  } in_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] result_real;
    logic signed [DataWidth-1:0] result_imag;
    status_e                     status;
  } out_t;

  // One result part on its way through the divider cells
  typedef struct packed {
    logic                  neg;
    logic                  big;   // quotient would not fit DataWidth bits
    logic [MagWidth-1:0]   rem;   // partial remainder, or final magnitude
    logic [DataWidth-1:0]  nlow;  // dividend bits still to bring down
    logic [DataWidth-1:0]  quo;
  } part_t;

  typedef struct packed {
    logic                is_div;
    logic                dz;
    logic [MagWidth-1:0] den;
    part_t               re;
    part_t               im;
  } cell_t;

endpackage

/* rtl/complex_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply and divide of signed Q8.8 complex operands.
// ----------------------------------------------------------------------------
// Takes one beat per cycle while not stalled and returns one result beat
// per input beat, in order. Each beat passes three front stages for
// products and sums, a row of DataWidth divider cells (16 at Q8.8) each
// producing one quotient bit, and the saturating output register. Every
// operation travels the full row, so results never overtake one another.
// A full output register holds while stalled; bubbles upstream still close up.
module complex_arithmetic_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  cau_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output cau_pkg::out_t out_data_o
);
  import cau_pkg::*;

  localparam logic [MagWidth-1:0] PosMax = MagWidth'((64'd1 << (DataWidth-1)) - 64'd1);
  localparam logic [MagWidth-1:0] NegMag = MagWidth'(64'd1 << (DataWidth-1));

  logic  front_ready;
  logic  v    [DataWidth+1];
  logic  rdy  [DataWidth+1];
  cell_t c    [DataWidth+1];

  logic  out_valid_q;
  out_t  out_data_q, out_data_d;
  logic  out_ready;

  cau_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (front_ready),
    .data_i  (in_data_i),
    .valid_o (v[0]),
    .ready_i (rdy[0]),
    .data_o  (c[0])
  );

  for (genvar k = 0; k < DataWidth; k++) begin : g_cell
    cau_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v[k]),
      .ready_o (rdy[k]),
      .data_i  (c[k]),
      .valid_o (v[k+1]),
      .ready_i (rdy[k+1]),
      .data_o  (c[k+1])
    );
  end

  assign out_ready       = !out_valid_q || !out_stall_i;
  assign rdy[DataWidth]  = out_ready;
  assign in_stall_o      = !front_ready;

  function automatic logic [DataWidth:0] sat_part(logic is_div, part_t p);
    logic [MagWidth-1:0] mag;
    logic                ovf;
    logic [MagWidth-1:0] val;
    mag = is_div ? MagWidth'(p.quo) : p.rem;
    ovf = 1'b0;
    if (is_div && p.big) begin
      ovf = 1'b1;
      val = p.neg ? NegMag : PosMax;
    end else if (mag == '0) begin
      val = '0;
    end else if (p.neg) begin
      if (mag > NegMag) begin
        ovf = 1'b1;
        val = NegMag;
      end else begin
        val = mag;
      end
    end else if (mag > PosMax) begin
      ovf = 1'b1;
      val = PosMax;
    end else begin
      val = mag;
    end
    if (p.neg) val = -val;
    return {ovf, val[DataWidth-1:0]};
  endfunction

  always_comb begin
    logic [DataWidth:0] pr, pi;
    pr = sat_part(c[DataWidth].is_div, c[DataWidth].re);
    pi = sat_part(c[DataWidth].is_div, c[DataWidth].im);
    if (c[DataWidth].dz) begin
      out_data_d.result_real = '0;
      out_data_d.result_imag = '0;
      out_data_d.status      = ST_DIV_ZERO;
    end else begin
      out_data_d.result_real = pr[DataWidth-1:0];
      out_data_d.result_imag = pi[DataWidth-1:0];
      out_data_d.status      = (pr[DataWidth] || pi[DataWidth]) ? ST_OVERFLOW : ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= v[DataWidth];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready) out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // divide by zero always yields a zero result
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_DIV_ZERO |->
      out_data_o.result_real == '0 && out_data_o.result_imag == '0)
    else $error("divide by zero beat carries a nonzero result");

  // an overflow beat has at least one part pinned at a rail
  a_ovf_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_OVERFLOW |->
      out_data_o.result_real == DataWidth'(PosMax) ||
      out_data_o.result_real == DataWidth'(NegMag) ||
      out_data_o.result_imag == DataWidth'(PosMax) ||
      out_data_o.result_imag == DataWidth'(NegMag))
    else $error("overflow status without a saturated part");

  // with the output register empty the whole row can move
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output register empty");

endmodule

/* rtl/cau_front.sv */
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Products, sums and divider set-up over three register stages.
// ----------------------------------------------------------------------------
module cau_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  cau_pkg::in_t  data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output cau_pkg::cell_t data_o
);
  import cau_pkg::*;

  logic v_a_q, v_b_q, v_c_q;
  logic rdy_a, rdy_b, rdy_c;

  // stage A
  op_e                        op_a_q;
  logic signed [MagWidth-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q, sq_r_q, sq_i_q;
  logic signed [DataWidth:0]  sr_q, si_q, sr_d, si_d;

  // stage B
  logic                is_div_b_q, is_div_b_d;
  logic                neg_r_q, neg_i_q, neg_r_d, neg_i_d;
  logic [MagWidth-1:0] mag_r_q, mag_i_q, mag_r_d, mag_i_d;
  logic [MagWidth-1:0] den_q, den_d;
  logic signed [MagWidth:0] s_re, s_im;

  // stage C
  cell_t c_q, c_d;
  logic [NumWidth-1:0] n_re, n_im;
  logic [NumWidth-DataWidth-1:0] hi_re, hi_im;

  assign rdy_c   = !v_c_q || ready_i;
  assign rdy_b   = !v_b_q || rdy_c;
  assign rdy_a   = !v_a_q || rdy_b;
  assign ready_o = rdy_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
      v_c_q <= 1'b0;
    end else begin
      if (rdy_a) v_a_q <= valid_i;
      if (rdy_b) v_b_q <= v_a_q;
      if (rdy_c) v_c_q <= v_b_q;
    end
  end

  always_comb begin
    if (data_i.operation == OP_SUB) begin
      sr_d = (DataWidth+1)'(data_i.a_real) - (DataWidth+1)'(data_i.b_real);
      si_d = (DataWidth+1)'(data_i.a_imag) - (DataWidth+1)'(data_i.b_imag);
    end else begin
      sr_d = (DataWidth+1)'(data_i.a_real) + (DataWidth+1)'(data_i.b_real);
      si_d = (DataWidth+1)'(data_i.a_imag) + (DataWidth+1)'(data_i.b_imag);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a) begin
      op_a_q <= data_i.operation;
      p_rr_q <= data_i.a_real * data_i.b_real;
      p_ii_q <= data_i.a_imag * data_i.b_imag;
      p_ri_q <= data_i.a_real * data_i.b_imag;
      p_ir_q <= data_i.a_imag * data_i.b_real;
      sq_r_q <= data_i.b_real * data_i.b_real;
      sq_i_q <= data_i.b_imag * data_i.b_imag;
      sr_q   <= sr_d;
      si_q   <= si_d;
    end
  end

  always_comb begin
    unique case (op_a_q)
      OP_MUL: begin
        s_re = (MagWidth+1)'(p_rr_q) - (MagWidth+1)'(p_ii_q);
        s_im = (MagWidth+1)'(p_ri_q) + (MagWidth+1)'(p_ir_q);
      end
      OP_DIV: begin
        s_re = (MagWidth+1)'(p_rr_q) + (MagWidth+1)'(p_ii_q);
        s_im = (MagWidth+1)'(p_ir_q) - (MagWidth+1)'(p_ri_q);
      end
      default: begin
        s_re = (MagWidth+1)'(sr_q);
        s_im = (MagWidth+1)'(si_q);
      end
    endcase
    neg_r_d = s_re[MagWidth];
    neg_i_d = s_im[MagWidth];
    mag_r_d = neg_r_d ? MagWidth'(-s_re) : MagWidth'(s_re);
    mag_i_d = neg_i_d ? MagWidth'(-s_im) : MagWidth'(s_im);
    // product magnitude truncated toward zero
    if (op_a_q == OP_MUL) begin
      mag_r_d = mag_r_d >> FracBits;
      mag_i_d = mag_i_d >> FracBits;
    end
    is_div_b_d = (op_a_q == OP_DIV);
    den_d      = MagWidth'(sq_r_q) + MagWidth'(sq_i_q);
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b) begin
      is_div_b_q <= is_div_b_d;
      neg_r_q    <= neg_r_d;
      neg_i_q    <= neg_i_d;
      mag_r_q    <= mag_r_d;
      mag_i_q    <= mag_i_d;
      den_q      <= den_d;
    end
  end

  // Dividend is mag * 2^FracBits; the top part must stay below den for
  // the quotient to fit DataWidth bits.
  always_comb begin
    n_re  = {mag_r_q, FracBits'(0)};
    n_im  = {mag_i_q, FracBits'(0)};
    hi_re = n_re[NumWidth-1:DataWidth];
    hi_im = n_im[NumWidth-1:DataWidth];

    c_d.is_div  = is_div_b_q;
    c_d.dz      = is_div_b_q && (den_q == '0);
    c_d.den     = den_q;
    c_d.re.neg  = neg_r_q;
    c_d.im.neg  = neg_i_q;
    c_d.re.big  = is_div_b_q && (NumWidth'(hi_re) >= NumWidth'(den_q));
    c_d.im.big  = is_div_b_q && (NumWidth'(hi_im) >= NumWidth'(den_q));
    c_d.re.nlow = n_re[DataWidth-1:0];
    c_d.im.nlow = n_im[DataWidth-1:0];
    c_d.re.quo  = '0;
    c_d.im.quo  = '0;
    c_d.re.rem  = is_div_b_q ? (c_d.re.big ? '0 : MagWidth'(hi_re)) : mag_r_q;
    c_d.im.rem  = is_div_b_q ? (c_d.im.big ? '0 : MagWidth'(hi_im)) : mag_i_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c) c_q <= c_d;
  end

  assign valid_o = v_c_q;
  assign data_o  = c_q;

endmodule

/* rtl/cau_cell.sv */
// ----------------------------------------------------------------------------
// Complex arithmetic unit divider cell
// One restoring-division quotient bit for both result parts per stage.
// ----------------------------------------------------------------------------
module cau_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  cau_pkg::cell_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output cau_pkg::cell_t data_o
);
  import cau_pkg::*;

  logic  valid_q;
  cell_t data_q, data_d;

  function automatic part_t div_step(part_t p, logic [MagWidth-1:0] den);
    logic [MagWidth:0] r2;
    logic              ge;
    part_t             n;
    r2     = {p.rem, p.nlow[DataWidth-1]};
    ge     = r2 >= {1'b0, den};
    n      = p;
    n.rem  = ge ? MagWidth'(r2 - {1'b0, den}) : MagWidth'(r2);
    n.nlow = {p.nlow[DataWidth-2:0], 1'b0};
    n.quo  = {p.quo[DataWidth-2:0], ge};
    return n;
  endfunction

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d = data_i;
    if (data_i.is_div) begin
      data_d.re = div_step(data_i.re, data_i.den);
      data_d.im = div_step(data_i.im, data_i.den);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* test/complex_arithmetic_unit_tb.sv */
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Drives directed and random operand beats through the valid/stall channels
// with random idling on both sides, predicts each result and checks it in
// order.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cau_pkg::*;

  class cau_scoreboard;
    out_t pending_q[$];
    int   errors;

    function new();
      errors = 0;
    endfunction

    // Sign-magnitude to saturated DataWidth value
    function automatic logic [DataWidth-1:0] saturate(logic neg, longint unsigned mag,
                                                      ref bit ovf);
      longint unsigned neg_mag;
      longint unsigned pos_max;
      neg_mag = 64'd1 << (DataWidth - 1);
      pos_max = neg_mag - 1;
      if (mag == 0) neg = 1'b0;
      if (neg) begin
        if (mag > neg_mag) begin
          ovf = 1'b1;
          mag = neg_mag;
        end
        return DataWidth'(-longint'(mag));
      end
      if (mag > pos_max) begin
        ovf = 1'b1;
        mag = pos_max;
      end
      return DataWidth'(mag);
    endfunction

    // floor(num * 2^FracBits / den), capped for huge quotients
    function automatic longint unsigned frac_quotient(longint unsigned num,
                                                      longint unsigned den);
      longint unsigned q;
      longint unsigned r;
      longint unsigned cap;
      bit b;
      q = num / den;
      r = num % den;
      cap = 64'd1 << 40;
      for (int i = 0; i < FracBits; i++) begin
        if (q > cap) return cap;
        b = r >= den - r;
        r = b ? r - (den - r) : r + r;
        q = (q << 1) | 64'(b);
      end
      return q;
    endfunction

    function automatic out_t complex_result(in_t beat);
      longint ar, ai, br, bi, sr, si;
      longint unsigned den, mr, mi;
      bit ovf;
      out_t res;
      ar = beat.a_real;
      ai = beat.a_imag;
      br = beat.b_real;
      bi = beat.b_imag;
      ovf = 1'b0;
      case (beat.operation)
        OP_ADD: begin
          sr = ar + br;
          si = ai + bi;
        end
        OP_SUB: begin
          sr = ar - br;
          si = ai - bi;
        end
        OP_MUL: begin
          // arithmetic shift floors, so shift the magnitude to truncate
          sr = ar * br - ai * bi;
          si = ar * bi + ai * br;
          sr = (sr < 0) ? -((-sr) >>> FracBits) : sr >>> FracBits;
          si = (si < 0) ? -((-si) >>> FracBits) : si >>> FracBits;
        end
        default: begin
          den = longint'(br * br) + longint'(bi * bi);
          if (den == 0) begin
            res.result_real = '0;
            res.result_imag = '0;
            res.status = ST_DIV_ZERO;
            return res;
          end
          sr = ar * br + ai * bi;
          si = ai * br - ar * bi;
          mr = frac_quotient((sr < 0) ? -sr : sr, den);
          mi = frac_quotient((si < 0) ? -si : si, den);
          res.result_real = saturate(sr < 0, mr, ovf);
          res.result_imag = saturate(si < 0, mi, ovf);
          res.status = ovf ? ST_OVERFLOW : ST_OK;
          return res;
        end
      endcase
      res.result_real = saturate(sr < 0, (sr < 0) ? -sr : sr, ovf);
      res.result_imag = saturate(si < 0, (si < 0) ? -si : si, ovf);
      res.status = ovf ? ST_OVERFLOW : ST_OK;
      return res;
    endfunction

    function void note_operands(in_t beat);
      pending_q.push_back(complex_result(beat));
    endfunction

    function void check_result(out_t got);
      out_t exp_r;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat %h", $time, got);
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.result_real !== exp_r.result_real) begin
        errors++;
        $display("%0t: result_real expected %h got %h", $time, exp_r.result_real,
                 got.result_real);
      end
      if (got.result_imag !== exp_r.result_imag) begin
        errors++;
        $display("%0t: result_imag expected %h got %h", $time, exp_r.result_imag,
                 got.result_imag);
      end
      if (got.status !== exp_r.status) begin
        errors++;
        $display("%0t: status expected %0d got %0d", $time, exp_r.status, got.status);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  cau_scoreboard results_sb = new();
  bit   calm = 1'b0;   // stretch with no idling on either side
  bit   stim_done = 1'b0;

  complex_arithmetic_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) results_sb.note_operands(in_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) results_sb.check_result(out_data_o);
  end

  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 21);
  end

  function automatic logic [15:0] edge_value();
    case ($urandom_range(7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hffff;
      4: return 16'h0100;
      5: return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  // Presents one beat and holds it until accepted; idles at random first
  task automatic send_operands(op_e op, logic [15:0] ar, logic [15:0] ai,
                               logic [15:0] br, logic [15:0] bi);
    while (!calm && $urandom_range(99) < 21) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{operation: op, a_real: ar, a_imag: ai, b_real: br, b_imag: bi};
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic send_random(int count);
    logic [15:0] v[4];
    for (int n = 0; n < count; n++) begin
      foreach (v[k]) v[k] = ($urandom_range(3) == 0) ? edge_value() : 16'($urandom);
      // small divisors stretch the quotient range
      if ($urandom_range(4) == 0) begin
        v[2] = 16'($signed(10'($urandom)));
        v[3] = 16'($signed(10'($urandom)));
      end
      if ($urandom_range(30) == 0) begin
        v[2] = '0;
        v[3] = '0;
      end
      send_operands(op_e'($urandom_range(3)), v[0], v[1], v[2], v[3]);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // directed: range extremes, every operation, divide by zero, overflow
    for (int o = 0; o < 4; o++) begin
      send_operands(op_e'(o), 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
      send_operands(op_e'(o), 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
      send_operands(op_e'(o), 16'h0100, 16'hff00, 16'h0200, 16'h0080);
      send_operands(op_e'(o), 16'h0000, 16'h0000, 16'h0001, 16'hffff);
    end
    send_operands(OP_DIV, 16'h1234, 16'h8000, 16'h0000, 16'h0000);
    send_operands(OP_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_operands(OP_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000);
    send_operands(OP_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_operands(OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_operands(OP_MUL, 16'hffff, 16'h0001, 16'h0001, 16'hffff);
    send_random(400);
    calm = 1'b1;
    send_random(250);
    calm = 1'b0;
    send_random(700);
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (results_sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (results_sb.errors == 0) begin
      $display("complex_arithmetic_unit verification clean");
    end else begin
      $display("complex_arithmetic_unit verification failed");
    end
    $finish;
  end

  initial begin
    #400us;
    $display("complex_arithmetic_unit verification failed");
    $finish;
  end

endmodule
